[hw/rtl/brrh_pkg.sv]
// ----------------------------------------------------------------------------
// brrh_pkg
// Shared types and constants for the byte ring with rewind history.
// ----------------------------------------------------------------------------
package brrh_pkg;

   localparam int unsigned RING_DEPTH_DEFAULT    = 4096;
   localparam int unsigned HISTORY_LIMIT_DEFAULT = 1024;

   localparam int unsigned POS_W      = 48;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned ACT_W      = 2;
   localparam int unsigned STAT_W     = 3;
   localparam int unsigned TDATA_W    = 56;
   localparam int unsigned CFG_DATA_W = 64;
   localparam int unsigned CFG_ADDR_W = 3;

   localparam logic [CFG_ADDR_W-1:0] ADDR_STREAM_LENGTH = 3'd0;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH = 2'd0,
      ACT_READ = 2'd1,
      ACT_SEEK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_FLUSHED  = 3'd3,
      ST_REJECTED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEEK_SKIP,
      SEEK_REWIND,
      SEEK_REJECT,
      SEEK_FLUSH
   } seek_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ_WAIT,
      S_SEEK_WAIT,
      S_RESULT
   } fsm_type;

   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] target;
      logic [POS_W-1:0] stream_length;
      logic [POS_W-1:0] reader_position;
   } seek_req_type;

   typedef struct packed {
      logic             done;
      seek_kind_type    kind;
      logic [POS_W-1:0] off;
      logic [POS_W-1:0] amount;
   } seek_res_type;

endpackage

[hw/rtl/byte_ring_with_rewind_history.sv]
// ----------------------------------------------------------------------------
// byte_ring_with_rewind_history
// Byte ring buffer with absolute stream positions and capped read history.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beats carry one command: push a byte, read a byte, or seek to an
//   absolute stream offset. Each command returns exactly one rsp_* beat with
//   a status, the byte read (zero unless a read succeeds) and the read
//   position after the command.
//   One command is in flight at a time. Push and the unused action go
//   straight to the result; a read of a non-empty ring waits on the
//   registered store read, and a seek on the three-stage seek classifier
//   plus apply. A new command is accepted only once the previous result is in the output register.
//   The csr_* port holds stream_length at byte address 0; write it only
//   while no command is in flight. Zero marks a live, unseekable stream.
//   Reset empties the ring, zeroes both positions and stream_length; store
//   contents stay undefined until written, and no clearing pass runs.
//   A stalled receiver holds the result in the output register; the next
//   command may still be accepted and waits for that register to drain.
// ----------------------------------------------------------------------------
module byte_ring_with_rewind_history #(
   parameter int unsigned RING_DEPTH    = brrh_pkg::RING_DEPTH_DEFAULT,
   parameter int unsigned HISTORY_LIMIT = brrh_pkg::HISTORY_LIMIT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: data_byte[7:0], target_offset[55:8]
   input  logic [brrh_pkg::TDATA_W-1:0]        req_tdata,
   // tuser: action[1:0]
   input  logic [brrh_pkg::ACT_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: read_byte[7:0], read_position[55:8]
   output logic [brrh_pkg::TDATA_W-1:0]        rsp_tdata,
   // tuser: status[2:0]
   output logic [brrh_pkg::STAT_W-1:0]         rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brrh_pkg::CFG_ADDR_W-1:0]     csr_paddr,
   input  logic [brrh_pkg::CFG_DATA_W-1:0]     csr_pwdata,
   output logic [brrh_pkg::CFG_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned POS_W  = brrh_pkg::POS_W;
   localparam int unsigned BYTE_W = brrh_pkg::BYTE_W;
   localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
   localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int unsigned HIST_W = $clog2(HISTORY_LIMIT + 1);
   localparam int unsigned SUM_W  = ((CNT_W > HIST_W) ? CNT_W : HIST_W) + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
   localparam logic [SUM_W-1:0] LIMIT_S = SUM_W'(HISTORY_LIMIT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   brrh_pkg::fsm_type    state_ff, state_in;
   brrh_pkg::action_type act_ff, act_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic [POS_W-1:0]     target_ff, target_in;
   logic [IDX_W-1:0]     read_index_ff, read_index_in;
   logic [IDX_W-1:0]     write_index_ff, write_index_in;
   logic [CNT_W-1:0]     buffered_ff, buffered_in;
   logic [HIST_W-1:0]    history_ff, history_in;
   logic [POS_W-1:0]     rpos_ff, rpos_in;
   logic [POS_W-1:0]     wpos_ff, wpos_in;
   logic [POS_W-1:0]     stream_length_ff, stream_length_in;
   brrh_pkg::status_type res_status_ff, res_status_in;
   logic [BYTE_W-1:0]    res_byte_ff, res_byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   brrh_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [BYTE_W-1:0]    rd_q_ff;
   logic                 mem_we;
   logic                 seek_start;
   logic                 cfg_we;

   logic [BYTE_W-1:0]    store [RING_DEPTH];

   logic [SUM_W-1:0]     used;
   logic                 full;
   logic [IDX_W-1:0]     wi_next, ri_next;
   logic [SUM_W-1:0]     hsum_one, hsum_amt;
   logic [HIST_W-1:0]    hist_inc, hist_skip;
   logic [CNT_W-1:0]     amt;
   logic [SUM_W-1:0]     ri_sum, rew_a, rew_b;
   logic [IDX_W-1:0]     skip_idx, rew_idx;

   brrh_pkg::seek_req_type seek_req;
   brrh_pkg::seek_res_type seek_res;

   assign seek_req.start           = seek_start;
   assign seek_req.target          = target_ff;
   assign seek_req.stream_length   = stream_length_ff;
   assign seek_req.reader_position = rpos_ff;

   brrh_seek #(
      .CNT_W  (CNT_W),
      .HIST_W (HIST_W)
   ) u_seek (
      .clock          (clock),
      .reset          (reset),
      .req            (seek_req),
      .buffered_count (buffered_ff),
      .history_count  (history_ff),
      .res            (seek_res)
   );

   assign used     = SUM_W'(buffered_ff) + SUM_W'(history_ff);
   assign full     = (used >= DEPTH_S);
   assign wi_next  = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + 1'b1;
   assign ri_next  = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
   assign hsum_one = SUM_W'(history_ff) + SUM_W'(1);
   assign hist_inc = (hsum_one > LIMIT_S) ? HIST_W'(HISTORY_LIMIT) : HIST_W'(hsum_one);
   assign amt      = seek_res.amount[CNT_W-1:0];
   assign hsum_amt = SUM_W'(history_ff) + SUM_W'(amt);
   assign hist_skip = (hsum_amt > LIMIT_S) ? HIST_W'(HISTORY_LIMIT) : HIST_W'(hsum_amt);
   assign ri_sum   = SUM_W'(read_index_ff) + SUM_W'(amt);
   assign skip_idx = (ri_sum >= DEPTH_S) ? IDX_W'(ri_sum - DEPTH_S) : IDX_W'(ri_sum);
   assign rew_a    = SUM_W'(read_index_ff) - SUM_W'(amt);
   assign rew_b    = SUM_W'(read_index_ff) + DEPTH_S - SUM_W'(amt);
   assign rew_idx  = (SUM_W'(read_index_ff) >= SUM_W'(amt)) ? IDX_W'(rew_a) : IDX_W'(rew_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brrh_pkg::S_IDLE: begin
            if (req_tvalid) state_in = brrh_pkg::S_EXEC;
         end
         brrh_pkg::S_EXEC: begin
            if (act_ff == brrh_pkg::ACT_READ && buffered_ff != '0) begin
               state_in = brrh_pkg::S_READ_WAIT;
            end else if (act_ff == brrh_pkg::ACT_SEEK) begin
               state_in = brrh_pkg::S_SEEK_WAIT;
            end else begin
               state_in = brrh_pkg::S_RESULT;
            end
         end
         brrh_pkg::S_READ_WAIT: state_in = brrh_pkg::S_RESULT;
         brrh_pkg::S_SEEK_WAIT: begin
            if (seek_res.done) state_in = brrh_pkg::S_RESULT;
         end
         brrh_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = brrh_pkg::S_IDLE;
         end
         default: state_in = brrh_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      mem_we         = 1'b0;
      seek_start     = 1'b0;
      act_in         = act_ff;
      data_in        = data_ff;
      target_in      = target_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      buffered_in    = buffered_ff;
      history_in     = history_ff;
      rpos_in        = rpos_ff;
      wpos_in        = wpos_ff;
      res_status_in  = res_status_ff;
      res_byte_in    = res_byte_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_pos_in     = rsp_pos_ff;
      case (state_ff)
         brrh_pkg::S_IDLE: begin
            req_tready = 1'b1;
            act_in     = brrh_pkg::action_type'(req_tuser);
            data_in    = req_tdata[BYTE_W-1:0];
            target_in  = req_tdata[BYTE_W +: POS_W];
         end
         brrh_pkg::S_EXEC: begin
            res_status_in = brrh_pkg::ST_OK;
            res_byte_in   = '0;
            case (act_ff)
               brrh_pkg::ACT_PUSH: begin
                  if (full && history_ff == '0) begin
                     res_status_in = brrh_pkg::ST_FULL;
                  end else begin
                     if (full) history_in = history_ff - 1'b1;
                     mem_we         = 1'b1;
                     write_index_in = wi_next;
                     buffered_in    = buffered_ff + 1'b1;
                     wpos_in        = wpos_ff + 1'b1;
                  end
               end
               brrh_pkg::ACT_READ: begin
                  if (buffered_ff == '0) res_status_in = brrh_pkg::ST_EMPTY;
               end
               brrh_pkg::ACT_SEEK: seek_start = 1'b1;
               default: res_status_in = brrh_pkg::ST_OK;
            endcase
         end
         brrh_pkg::S_READ_WAIT: begin
            res_byte_in   = rd_q_ff;
            read_index_in = ri_next;
            buffered_in   = buffered_ff - 1'b1;
            rpos_in       = rpos_ff + 1'b1;
            history_in    = hist_inc;
         end
         brrh_pkg::S_SEEK_WAIT: begin
            if (seek_res.done) begin
               case (seek_res.kind)
                  brrh_pkg::SEEK_SKIP: begin
                     read_index_in = skip_idx;
                     buffered_in   = buffered_ff - amt;
                     history_in    = hist_skip;
                     rpos_in       = seek_res.off;
                  end
                  brrh_pkg::SEEK_REWIND: begin
                     read_index_in = rew_idx;
                     buffered_in   = buffered_ff + amt;
                     history_in    = history_ff - HIST_W'(amt);
                     rpos_in       = seek_res.off;
                  end
                  brrh_pkg::SEEK_REJECT: res_status_in = brrh_pkg::ST_REJECTED;
                  brrh_pkg::SEEK_FLUSH: begin
                     read_index_in  = '0;
                     write_index_in = '0;
                     buffered_in    = '0;
                     history_in     = '0;
                     rpos_in        = seek_res.off;
                     wpos_in        = seek_res.off;
                     res_status_in  = brrh_pkg::ST_FLUSHED;
                  end
                  default: res_status_in = brrh_pkg::ST_REJECTED;
               endcase
            end
         end
         brrh_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_byte_in   = res_byte_ff;
               rsp_pos_in    = rpos_ff;
            end
         end
         default: req_tready = 1'b0;
      endcase
   end

   assign cfg_we = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == brrh_pkg::ADDR_STREAM_LENGTH);
   assign stream_length_in = cfg_we ? csr_pwdata[POS_W-1:0] : stream_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= brrh_pkg::S_IDLE;
         read_index_ff    <= '0;
         write_index_ff   <= '0;
         buffered_ff      <= '0;
         history_ff       <= '0;
         rpos_ff          <= '0;
         wpos_ff          <= '0;
         stream_length_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         read_index_ff    <= read_index_in;
         write_index_ff   <= write_index_in;
         buffered_ff      <= buffered_in;
         history_ff       <= history_in;
         rpos_ff          <= rpos_in;
         wpos_ff          <= wpos_in;
         stream_length_ff <= stream_length_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      act_ff        <= act_in;
      data_ff       <= data_in;
      target_ff     <= target_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) store[write_index_ff] <= data_ff;
      rd_q_ff <= store[read_index_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == brrh_pkg::ADDR_STREAM_LENGTH)
                       ? brrh_pkg::CFG_DATA_W'(stream_length_ff) : '0;

endmodule

[hw/rtl/brrh_seek.sv]
// ----------------------------------------------------------------------------
// brrh_seek
// Three-stage seek classifier: clamp the target, take distances to the read
// point, then pick skip, rewind, reject or flush.
// ----------------------------------------------------------------------------
module brrh_seek #(
   parameter int unsigned CNT_W  = 13,
   parameter int unsigned HIST_W = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brrh_pkg::seek_req_type req,
   input  logic [CNT_W-1:0]      buffered_count,
   input  logic [HIST_W-1:0]     history_count,
   output brrh_pkg::seek_res_type res
);

   localparam int unsigned POS_W = brrh_pkg::POS_W;

   logic             v1_ff, v2_ff;
   logic             seekable1_ff, seekable1_in, seekable2_ff;
   logic [POS_W-1:0] off1_ff, off1_in, off2_ff;
   logic [POS_W-1:0] fwd2_ff, back2_ff;
   logic             ge2_ff;
   brrh_pkg::seek_res_type res_ff, res_in;
   logic [POS_W-1:0] buf_ext, hist_ext;

   always_comb begin
      seekable1_in = (req.stream_length != '0);
      off1_in      = req.target;
      if (seekable1_in && (req.target > req.stream_length)) begin
         off1_in = req.stream_length;
      end
   end

   assign buf_ext  = POS_W'(buffered_count);
   assign hist_ext = POS_W'(history_count);

   always_comb begin
      res_in      = res_ff;
      res_in.done = v2_ff;
      res_in.off  = off2_ff;
      if (ge2_ff && (fwd2_ff < buf_ext)) begin
         res_in.kind   = brrh_pkg::SEEK_SKIP;
         res_in.amount = fwd2_ff;
      end else if (!ge2_ff && (back2_ff <= hist_ext)) begin
         res_in.kind   = brrh_pkg::SEEK_REWIND;
         res_in.amount = back2_ff;
      end else if (!seekable2_ff) begin
         res_in.kind   = brrh_pkg::SEEK_REJECT;
         res_in.amount = '0;
      end else begin
         res_in.kind   = brrh_pkg::SEEK_FLUSH;
         res_in.amount = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         v1_ff       <= req.start;
         v2_ff       <= v1_ff;
         res_ff.done <= res_in.done;
      end
      off1_ff       <= off1_in;
      seekable1_ff  <= seekable1_in;
      off2_ff       <= off1_ff;
      seekable2_ff  <= seekable1_ff;
      ge2_ff        <= (off1_ff >= req.reader_position);
      fwd2_ff       <= off1_ff - req.reader_position;
      back2_ff      <= req.reader_position - off1_ff;
      res_ff.kind   <= res_in.kind;
      res_ff.off    <= res_in.off;
      res_ff.amount <= res_in.amount;
   end

   assign res = res_ff;

endmodule

[hw/rtl/brrh_checker.sv]
// ----------------------------------------------------------------------------
// brrh_checker
// Port-level checks for the byte ring with rewind history.
// ----------------------------------------------------------------------------
module brrh_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [brrh_pkg::TDATA_W-1:0]  rsp_tdata,
   input logic [brrh_pkg::STAT_W-1:0]   rsp_tuser
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= brrh_pkg::STAT_W'(brrh_pkg::ST_REJECTED))
      else $error("status code out of range");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != brrh_pkg::STAT_W'(brrh_pkg::ST_OK)
      |-> rsp_tdata[brrh_pkg::BYTE_W-1:0] == '0)
      else $error("read byte nonzero on failed command");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command accepted while one is in flight");

endmodule

bind byte_ring_with_rewind_history brrh_checker u_brrh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
